// ----- rtl/mpr_pkg.sv -----
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants for the multilevel priority round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

  localparam int PRIO_W  = 3;
  localparam int LEN_W   = 8;
  localparam int ID_W    = 16;
  localparam int QUANT_W = 8;

  localparam int QUEUE_DEPTH_DEF     = 16;
  localparam int PRIORITY_LEVELS_DEF = 4;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd2;
  localparam logic [ID_W-1:0]    ID_RESET      = 16'd1;

  typedef struct packed {
    logic              arrival_valid;
    logic [PRIO_W-1:0] arrival_priority;
    logic [LEN_W-1:0]  arrival_length;
  } in_item_t;

  typedef struct packed {
    logic              job_served;
    logic [ID_W-1:0]   served_id;
    logic [PRIO_W-1:0] served_priority;
    logic              job_finished;
    logic [LEN_W-1:0]  remaining_length;
    logic              arrival_dropped;
  } out_item_t;

  // One job store entry: id above remaining length.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } job_word_t;

  // Queue bookkeeping commands for one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mpr_job_ram.sv -----
// ----------------------------------------------------------------------------
// mpr_job_ram
// Job store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_job_ram #(
  parameter int SLOTS  = mpr_pkg::QUEUE_DEPTH_DEF * mpr_pkg::PRIORITY_LEVELS_DEF,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire mpr_pkg::job_word_t wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output      mpr_pkg::job_word_t rd_data
);

  mpr_pkg::job_word_t mem [SLOTS];
  mpr_pkg::job_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/mpr_queue_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpr_queue_ctrl
// Per-level head/tail pointers and fill counts, plus service level select.
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_queue_ctrl #(
  parameter int QUEUE_DEPTH     = mpr_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIORITY_LEVELS = mpr_pkg::PRIORITY_LEVELS_DEF,
  parameter int PTR_W           = $clog2(QUEUE_DEPTH),
  parameter int LVL_W           = $clog2(PRIORITY_LEVELS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mpr_pkg::q_cmd_t  cmd,
  input  wire logic [LVL_W-1:0] push_lvl,
  output      logic             push_full,
  output      logic [PTR_W-1:0] tail_ptr,
  output      logic             svc_any,
  output      logic [LVL_W-1:0] svc_lvl,
  output      logic             svc_was_empty,
  output      logic [PTR_W-1:0] head_ptr
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_r [PRIORITY_LEVELS];
  logic [PTR_W-1:0] tail_r [PRIORITY_LEVELS];
  logic [CNT_W-1:0] cnt_r  [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] nonempty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_full = (cnt_r[push_lvl] == CNT_W'(QUEUE_DEPTH));
  assign tail_ptr  = tail_r[push_lvl];

  // A same-cycle push counts as occupancy for the service pick.
  always_comb begin
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      nonempty[l] = (cnt_r[l] != '0) || (cmd.push && (push_lvl == LVL_W'(l)));
    end
  end

  // Highest nonempty level wins.
  always_comb begin
    svc_any = 1'b0;
    svc_lvl = '0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (nonempty[l]) begin
        svc_any = 1'b1;
        svc_lvl = LVL_W'(l);
      end
    end
  end

  assign svc_was_empty = (cnt_r[svc_lvl] == '0);
  assign head_ptr      = head_r[svc_lvl];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        if (cmd.push && (push_lvl == LVL_W'(l))) begin
          tail_r[l] <= ptr_inc(tail_r[l]);
        end
        if (cmd.pop && (svc_lvl == LVL_W'(l))) begin
          head_r[l] <= ptr_inc(head_r[l]);
        end
        if ((cmd.push && (push_lvl == LVL_W'(l))) && !(cmd.pop && (svc_lvl == LVL_W'(l)))) begin
          cnt_r[l] <= cnt_r[l] + 1'b1;
        end else if (!(cmd.push && (push_lvl == LVL_W'(l))) &&
                     (cmd.pop && (svc_lvl == LVL_W'(l)))) begin
          cnt_r[l] <= cnt_r[l] - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multilevel_priority_round_robin.sv -----
// ----------------------------------------------------------------------------
// multilevel_priority_round_robin
// Multilevel FIFO scheduler: per-level round robin, strict priority between
// levels, quantum-based time slicing.
// Use: each input transaction is one scheduler tick. It may carry a new job
//   (priority, length); the job takes the next 16-bit id and joins the tail of
//   its level FIFO, or is dropped and flagged when that FIFO is full. The head
//   of the highest nonempty level is then served for one quantum; it finishes
//   or goes back to the tail of its own level. Both channels are valid/stall.
//   The user must write quantum_size over cfg_wr_en/cfg_wr_data only while
//   the block is idle; the block itself does not enforce this.
// Timing: the accept cycle pushes the arrival, picks the level and issues the
//   job store read; the next cycle finishes the read-modify-write (requeue)
//   and loads the result register, raising out_valid. A new tick is taken
//   only once the sequencer is back in idle.
// Reset: synchronous, active low. All FIFOs empty, next id 1, quantum 2. The
//   job store is not cleared; only occupied entries are ever read.
// Stall: a result waits in the output register while out_stall is high; the
//   next tick lands in a holding register and the input stays stalled until
//   the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_round_robin #(
  parameter int QUEUE_DEPTH     = mpr_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIORITY_LEVELS = mpr_pkg::PRIORITY_LEVELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire mpr_pkg::in_item_t                in_data,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      mpr_pkg::out_item_t               out_data,
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [mpr_pkg::QUANT_W-1:0]      cfg_wr_data
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
  localparam int SLOTS  = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t state_r;

  // quantum register
  logic [mpr_pkg::QUANT_W-1:0] quantum_r;

  // tick context captured at accept
  logic [mpr_pkg::ID_W-1:0] next_id_r;
  logic [LVL_W-1:0]         svc_lvl_r;
  logic                     served_r;
  logic                     bypass_r;
  logic                     dropped_r;
  mpr_pkg::job_word_t       byp_word_r;

  // result staging
  mpr_pkg::out_item_t res_r;
  mpr_pkg::out_item_t out_data_r;
  logic               out_valid_r;

  // queue control hookup
  mpr_pkg::q_cmd_t  q_cmd;
  logic [LVL_W-1:0] arr_lvl;
  logic [LVL_W-1:0] push_lvl;
  logic             push_full;
  logic [PTR_W-1:0] tail_ptr;
  logic             svc_any;
  logic [LVL_W-1:0] svc_lvl;
  logic             svc_was_empty;
  logic [PTR_W-1:0] head_ptr;

  // job store hookup
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  mpr_pkg::job_word_t ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  mpr_pkg::job_word_t ram_rd_data;

  logic               accept;
  logic               arr_push;
  logic               requeue;
  logic               out_free;
  logic               load_out;
  mpr_pkg::job_word_t arr_word;
  mpr_pkg::job_word_t cur_word;
  logic               fin;
  logic [mpr_pkg::LEN_W-1:0] rem;
  mpr_pkg::out_item_t res;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  // Ticks are taken only between jobs; the sequencer owns the store.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // A finished tick moves into the output register.
  assign load_out = ((state_r == S_RUN) || (state_r == S_WAIT)) && out_free;

  // Out-of-range priority lands in the lowest level.
  always_comb begin
    if ((in_data.arrival_priority != '0) &&
        (int'(in_data.arrival_priority) <= PRIORITY_LEVELS)) begin
      arr_lvl = LVL_W'(int'(in_data.arrival_priority) - 1);
    end else begin
      arr_lvl = '0;
    end
  end

  // One push port: arrival in the accept cycle, requeue in the run cycle.
  assign push_lvl = (state_r == S_IDLE) ? arr_lvl : svc_lvl_r;
  assign arr_push = accept && in_data.arrival_valid && !push_full;

  assign cur_word = bypass_r ? byp_word_r : ram_rd_data;
  assign fin      = (cur_word.len <= quantum_r);
  assign rem      = cur_word.len - quantum_r;
  assign requeue  = (state_r == S_RUN) && served_r && !fin;

  assign q_cmd.push = arr_push || requeue;
  assign q_cmd.pop  = accept && svc_any;

  assign arr_word.id  = next_id_r;
  assign arr_word.len = in_data.arrival_length;

  assign ram_wr_en   = q_cmd.push;
  assign ram_wr_addr = slot_addr(push_lvl, tail_ptr);
  always_comb begin
    if (arr_push) begin
      ram_wr_data = arr_word;
    end else begin
      ram_wr_data.id  = cur_word.id;
      ram_wr_data.len = rem;
    end
  end

  // Served job that was just pushed into an empty level comes from the bypass,
  // never from the store (same entry is being written).
  assign ram_rd_en   = accept && svc_any && !svc_was_empty;
  assign ram_rd_addr = slot_addr(svc_lvl, head_ptr);

  always_comb begin
    res = '0;
    res.arrival_dropped = dropped_r;
    if (served_r) begin
      res.job_served       = 1'b1;
      res.served_id        = cur_word.id;
      res.served_priority  = mpr_pkg::PRIO_W'(int'(svc_lvl_r) + 1);
      res.job_finished     = fin;
      res.remaining_length = fin ? '0 : rem;
    end
  end

  mpr_queue_ctrl #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .PTR_W           (PTR_W),
    .LVL_W           (LVL_W)
  ) u_queue_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (q_cmd),
    .push_lvl      (push_lvl),
    .push_full     (push_full),
    .tail_ptr      (tail_ptr),
    .svc_any       (svc_any),
    .svc_lvl       (svc_lvl),
    .svc_was_empty (svc_was_empty),
    .head_ptr      (head_ptr)
  );

  mpr_job_ram #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= mpr_pkg::QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum_r <= cfg_wr_data;
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_id_r   <= mpr_pkg::ID_RESET;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.arrival_valid) begin
              next_id_r <= next_id_r + 1'b1;
            end
            svc_lvl_r  <= svc_lvl;
            served_r   <= svc_any;
            bypass_r   <= svc_was_empty;
            byp_word_r <= arr_word;
            dropped_r  <= in_data.arrival_valid && push_full;
            state_r    <= S_RUN;
          end
        end
        S_RUN: begin
          res_r <= res;
          if (out_free) begin
            out_data_r <= res;
            state_r    <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The run step always follows an accepted tick.
  a_run_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> $past(accept))
    else $error("run step without accepted tick");

  // Store never sees a read and a write of the same entry in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("job store read/write collision");

  // A requeue only happens in the run step of a served tick.
  a_requeue_served: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cmd.push && !accept) |-> ((state_r == S_RUN) && served_r && !fin))
    else $error("unexpected queue push");

  // Finished implies served on the result channel.
  a_fin_served: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.job_finished) |-> out_data.job_served)
    else $error("finished without service");

endmodule

`default_nettype wire
